FILE: sv/a85_pkg.sv
// Shared types, constants and helper functions for the ASCII85 stream decoder.
package a85_pkg;

  localparam logic [7:0] CharTilde = 8'h7E;
  localparam logic [7:0] CharZ     = 8'h7A;
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] DigitLo   = 8'd33;
  localparam logic [7:0] DigitHi   = 8'd117;
  localparam logic [7:0] LtValue   = 8'd27;
  localparam logic [2:0] GroupLen  = 3'd5;
  localparam logic [2:0] MaxBytes  = 3'd4;

  typedef struct packed {
    logic        at_start;
    logic        pending_lt;
    logic [31:0] accumulator;
    logic [2:0]  digit_count;
    logic        stopped;
    logic        error_seen;
  } state_t;

  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
    logic            byte_valid;
    logic            last;
    logic            err;
  } result_t;

  localparam state_t StateReset = '{
    at_start: 1'b1, pending_lt: 1'b0, accumulator: 32'd0,
    digit_count: 3'd0, stopped: 1'b0, error_seen: 1'b0
  };

  // Power of 85 that pads a partial group of the given digit count to five digits.
  function automatic logic [31:0] pad_pow(input logic [2:0] cnt);
    logic [31:0] p;
    case (cnt)
      3'd1:    p = 32'd52200625;
      3'd2:    p = 32'd614125;
      3'd3:    p = 32'd7225;
      3'd4:    p = 32'd85;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

FILE: sv/a85_step.sv
// Combinational next-state and result logic for one input word of the decoder.
module a85_step (
  input  a85_pkg::state_t  st,
  input  logic [7:0]       text_char,
  input  logic             end_of_text,
  output a85_pkg::state_t  st_next,
  output a85_pkg::result_t res
);

  logic [31:0] base_acc;
  logic [2:0]  base_cnt;
  logic [31:0] digit_acc;
  logic [2:0]  digit_cnt;
  logic [31:0] padded;
  logic [7:0]  digit_val;
  logic        proceed;
  logic        is_digit;

  assign base_acc  = st.pending_lt ? {24'd0, a85_pkg::LtValue} : st.accumulator;
  assign base_cnt  = st.pending_lt ? 3'd1 : st.digit_count;
  assign digit_val = text_char - a85_pkg::DigitLo;
  assign digit_acc = 32'(base_acc * 32'd85) + {24'd0, digit_val};
  assign digit_cnt = base_cnt + 3'd1;
  assign padded    = 32'((base_acc + 32'd1) * a85_pkg::pad_pow(base_cnt)) - 32'd1;
  assign is_digit  = (text_char >= a85_pkg::DigitLo) && (text_char <= a85_pkg::DigitHi);

  always_comb begin
    st_next        = st;
    res.count      = 3'd0;
    res.bytes      = '0;
    res.byte_valid = 1'b0;
    res.last       = 1'b0;
    res.err        = 1'b0;
    proceed        = 1'b0;

    if (end_of_text) begin
      st_next  = a85_pkg::StateReset;
      res.last = 1'b1;
      if (st.error_seen) begin
        res.count = 3'd1;
        res.err   = 1'b1;
      end else if (base_cnt == 3'd0) begin
        res.count = 3'd1;
      end else begin
        res.byte_valid = 1'b1;
        res.count      = (base_cnt == 3'd1) ? 3'd1 : base_cnt - 3'd1;
        res.bytes[0]   = padded[31:24];
        res.bytes[1]   = padded[23:16];
        res.bytes[2]   = padded[15:8];
      end
    end else if (!(st.error_seen || st.stopped)) begin
      if (st.pending_lt) begin
        st_next.pending_lt = 1'b0;
        st_next.at_start   = 1'b0;
        proceed            = (text_char != a85_pkg::CharTilde);
      end else if (st.at_start) begin
        if (!a85_pkg::is_space(text_char)) begin
          st_next.at_start = 1'b0;
          if (text_char == a85_pkg::CharLt) begin
            st_next.pending_lt = 1'b1;
          end else begin
            proceed = 1'b1;
          end
        end
      end else begin
        proceed = 1'b1;
      end

      if (proceed) begin
        st_next.accumulator = base_acc;
        st_next.digit_count = base_cnt;
        if (text_char == a85_pkg::CharTilde) begin
          st_next.stopped = 1'b1;
        end else if (a85_pkg::is_space(text_char)) begin
          st_next.stopped = st.stopped;
        end else if ((text_char == a85_pkg::CharZ) && (base_cnt == 3'd0)) begin
          res.count      = a85_pkg::MaxBytes;
          res.byte_valid = 1'b1;
        end else if (!is_digit) begin
          st_next.error_seen = 1'b1;
        end else if (digit_cnt == a85_pkg::GroupLen) begin
          st_next.accumulator = 32'd0;
          st_next.digit_count = 3'd0;
          res.count           = a85_pkg::MaxBytes;
          res.byte_valid      = 1'b1;
          res.bytes[0]        = digit_acc[31:24];
          res.bytes[1]        = digit_acc[23:16];
          res.bytes[2]        = digit_acc[15:8];
          res.bytes[3]        = digit_acc[7:0];
        end else begin
          st_next.accumulator = digit_acc;
          st_next.digit_count = digit_cnt;
        end
      end
    end
  end

endmodule

FILE: sv/ascii85_stream_decoder_top.sv
// Top level of the ASCII85 stream decoder: input register, decode step and output buffer.
// A word is registered at acceptance; its results load the output buffer once it has room.
// Throughput: one input word per cycle while each yields at most one result and out_stall
// is low; a word with more results holds the input until its last byte is being taken.
// Reset: synchronous, active high; clears the decoder to the start of a new text
// and empties the input register and the output buffer.
module ascii85_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_char,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       last,
  output logic       decode_error
);

  logic              s1_valid;
  logic [7:0]        s1_char;
  logic              s1_eot;
  logic              s1_take;
  logic              buf_free;
  a85_pkg::state_t   st;
  a85_pkg::state_t   st_next;
  a85_pkg::result_t  res;
  logic [2:0]        ob_count;
  logic [3:0][7:0]   ob_bytes;
  logic              ob_bv;
  logic              ob_last;
  logic              ob_err;

  a85_step u_step (
    .st          (st),
    .text_char   (s1_char),
    .end_of_text (s1_eot),
    .st_next     (st_next),
    .res         (res)
  );

  assign buf_free = (ob_count == 3'd0) || ((ob_count == 3'd1) && !out_stall);
  assign s1_take  = s1_valid && buf_free;
  assign in_stall = s1_valid && !s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_char <= text_char;
      s1_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= a85_pkg::StateReset;
      ob_count <= 3'd0;
    end else if (s1_take) begin
      st       <= st_next;
      ob_count <= res.count;
    end else if (out_valid && !out_stall) begin
      ob_count <= ob_count - 3'd1;
    end
    if (s1_take) begin
      ob_bytes <= res.bytes;
      ob_bv    <= res.byte_valid;
      ob_last  <= res.last;
      ob_err   <= res.err;
    end else if (out_valid && !out_stall) begin
      ob_bytes <= {8'd0, ob_bytes[3:1]};
    end
  end

  assign out_valid    = (ob_count != 3'd0);
  assign data_byte    = ob_bytes[0];
  assign byte_valid   = ob_bv;
  assign last         = ob_last && (ob_count == 3'd1);
  assign decode_error = ob_err && (ob_count == 3'd1);

  a_no_byte_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> last)
    else $error("result without a byte is not the final one");

  a_error_only_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && decode_error) |-> (last && !byte_valid))
    else $error("error flag on a non-final or byte-carrying result");

  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    (st.digit_count <= 3'd4) && (ob_count <= a85_pkg::MaxBytes))
    else $error("digit count or buffer fill out of range");

  a_take_empties: assert property (@(posedge clk) disable iff (rst)
    (s1_take && res.count == 3'd0) |=> !out_valid)
    else $error("buffer not empty after a word with no results");

endmodule

FILE: tb/ascii85_stream_decoder_top_tb.sv
// Self-checking testbench for the ASCII85 stream decoder: directed table and random texts.
module ascii85_stream_decoder_top_tb;

  localparam logic [31:0] Base85     = 32'd85;
  localparam logic [31:0] PadDigit   = 32'd84;
  localparam logic [7:0]  TabCode    = 8'd9;
  localparam logic [7:0]  CrCode     = 8'd13;
  localparam int          TotalItems = 240;
  localparam int          CalmAfter  = 205;
  localparam int          LongHold   = 300;
  localparam int          IdleLimit  = 2000;
  localparam int          DrainCycles = 16;
  localparam int          ReportMax  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       err;
  } a85_out_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    int         n;
    logic [7:0] b;
    logic       v;
    logic       e;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] text_char;
  logic       end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  logic       decode_error;

  logic        txt_at_start;
  logic        lt_held;
  logic [31:0] acc;
  logic [2:0]  ndig;
  logic        halted;
  logic        bad_seen;

  a85_out_t  step_out [4];
  int        step_n;
  a85_out_t  expected_bytes [$];
  stim_row_t dir_rows [$];
  int        items_sent = 0;
  int        mismatches = 0;
  int        got_count = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;
  bit        long_done = 1'b0;

  ascii85_stream_decoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_char    (text_char),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .decode_error (decode_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_decoder();
    txt_at_start = 1'b1;
    lt_held      = 1'b0;
    acc          = 32'd0;
    ndig         = 3'd0;
    halted       = 1'b0;
    bad_seen     = 1'b0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == a85_pkg::CharSpace) || ((c >= TabCode) && (c <= CrCode));
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    step_out[step_n] = {b, 1'b1, 1'b0, 1'b0};
    step_n++;
  endfunction

  function automatic void add_digit_val(input logic [31:0] v);
    acc  = acc * Base85 + v;
    ndig = ndig + 3'd1;
    if (ndig >= a85_pkg::GroupLen) begin
      emit_byte(acc[31:24]);
      emit_byte(acc[23:16]);
      emit_byte(acc[15:8]);
      emit_byte(acc[7:0]);
      acc  = 32'd0;
      ndig = 3'd0;
    end
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic eot);
    logic err;
    int   i;
    step_n = 0;
    if (eot) begin
      err = bad_seen;
      if (!err) begin
        if (lt_held) add_digit_val(32'(a85_pkg::LtValue));
        if (ndig != 3'd0) begin
          for (i = int'(ndig); i < int'(a85_pkg::GroupLen); i++)
            acc = acc * Base85 + PadDigit;
          emit_byte(acc[31:24]);
          if (ndig >= 3'd3) emit_byte(acc[23:16]);
          if (ndig >= 3'd4) emit_byte(acc[15:8]);
        end
      end
      if (step_n == 0) begin
        step_out[0] = '0;
        step_n = 1;
      end
      step_out[step_n - 1].last = 1'b1;
      step_out[step_n - 1].err  = err;
      clear_decoder();
      return;
    end
    if (bad_seen || halted) return;
    if (lt_held) begin
      lt_held      = 1'b0;
      txt_at_start = 1'b0;
      if (c == a85_pkg::CharTilde) return;
      add_digit_val(32'(a85_pkg::LtValue));
    end else if (txt_at_start) begin
      if (is_blank(c)) return;
      txt_at_start = 1'b0;
      if (c == a85_pkg::CharLt) begin
        lt_held = 1'b1;
        return;
      end
    end
    if (c == a85_pkg::CharTilde) begin
      halted = 1'b1;
      return;
    end
    if (is_blank(c)) return;
    if ((c == a85_pkg::CharZ) && (ndig == 3'd0)) begin
      emit_byte(8'h00);
      emit_byte(8'h00);
      emit_byte(8'h00);
      emit_byte(8'h00);
      return;
    end
    if ((c < a85_pkg::DigitLo) || (c > a85_pkg::DigitHi)) begin
      bad_seen = 1'b1;
      step_n   = 0;
      return;
    end
    add_digit_val(32'(c - a85_pkg::DigitLo));
  endfunction

  function automatic void add_row(input logic [7:0] ch, input logic eot, input int n,
                                  input logic [7:0] b, input logic v, input logic e);
    stim_row_t r;
    r.ch  = ch;
    r.eot = eot;
    r.n   = n;
    r.b   = b;
    r.v   = v;
    r.e   = e;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] pick_char();
    int   r;
    int   k;
    r = $urandom_range(0, 99);
    if (r < 72) return 8'($urandom_range(33, 117));
    if (r < 82) begin
      k = $urandom_range(9, 14);
      return (k == 14) ? a85_pkg::CharSpace : 8'(k);
    end
    if (r < 88) return a85_pkg::CharZ;
    if (r < 91) return a85_pkg::CharTilde;
    if (r < 94) return a85_pkg::CharLt;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic eot, input int typed_n,
                           input logic [7:0] typed_b, input logic typed_v,
                           input logic typed_e);
    int i;
    calm = (items_sent >= CalmAfter);
    if (!calm && ($urandom_range(0, 5) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_char   <= ch;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    decode_char(ch, eot);
    if (typed_n < 0) begin
      for (i = 0; i < step_n; i++) expected_bytes.push_back(step_out[i]);
    end else begin
      for (i = 0; i < typed_n; i++)
        expected_bytes.push_back({typed_b, typed_v, eot && (i == typed_n - 1),
                                  typed_e && (i == typed_n - 1)});
    end
  endtask

  initial begin
    int len;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    text_char   <= a85_pkg::CharSpace;
    end_of_text <= 1'b0;
    out_stall   <= 1'b0;
    clear_decoder();

    add_row(8'h01, 1'b1, 1, 8'h00, 1'b0, 1'b0);
    add_row(a85_pkg::CharZ, 1'b0, 4, 8'h00, 1'b1, 1'b0);
    add_row(8'h01, 1'b1, 1, 8'h00, 1'b0, 1'b0);
    add_row(a85_pkg::CharLt, 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row(a85_pkg::CharTilde, 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row("s", 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row("8", 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row("W", 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row("-", 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row("!", 1'b0, 4, 8'hFF, 1'b1, 1'b0);
    add_row(a85_pkg::CharTilde, 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row("x", 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row(8'h01, 1'b1, 1, 8'h00, 1'b0, 1'b0);
    add_row(TabCode, 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row(a85_pkg::CharLt, 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row("A", 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row(8'h01, 1'b1, -1, 8'h00, 1'b0, 1'b0);
    add_row("!", 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row(a85_pkg::CharZ, 1'b0, 0, 8'h00, 1'b0, 1'b0);
    add_row(8'h01, 1'b1, 1, 8'h00, 1'b0, 1'b1);
    add_row(8'hFF, 1'b0, 0, 8'h00, 1'b0, 1'b0);
    add_row(8'hFF, 1'b1, 1, 8'h00, 1'b0, 1'b1);
    add_row(a85_pkg::CharLt, 1'b0, -1, 8'h00, 1'b0, 1'b0);
    add_row(8'h01, 1'b1, -1, 8'h00, 1'b0, 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[j])
      send_char(dir_rows[j].ch, dir_rows[j].eot, dir_rows[j].n, dir_rows[j].b,
                dir_rows[j].v, dir_rows[j].e);

    while (items_sent < TotalItems) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 1)
          send_char(a85_pkg::CharSpace, 1'b0, -1, 8'h00, 1'b0, 1'b0);
        send_char(a85_pkg::CharLt, 1'b0, -1, 8'h00, 1'b0, 1'b0);
        send_char(a85_pkg::CharTilde, 1'b0, -1, 8'h00, 1'b0, 1'b0);
      end
      len = $urandom_range(0, 24);
      repeat (len) send_char(pick_char(), 1'b0, -1, 8'h00, 1'b0, 1'b0);
      send_char(8'($urandom_range(1, 255)), 1'b1, -1, 8'h00, 1'b0, 1'b0);
    end
    in_valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (!long_done && (got_count >= 60)) begin
          long_done = 1'b1;
          out_stall <= 1'b1;
          repeat (LongHold) @(posedge clk);
          out_stall <= 1'b0;
        end else if (!calm && ($urandom_range(0, 4) == 0)) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 16)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    a85_out_t got;
    a85_out_t want;
    if (!rst && out_valid && !out_stall) begin
      got_count++;
      got = {data_byte, byte_valid, last, decode_error};
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("Unexpected result: data %02h valid %b last %b error %b",
                   got.data, got.valid, got.last, got.err);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display({"Result %0d: expected data %02h valid %b last %b error %b, ",
                      "got data %02h valid %b last %b error %b"},
                     got_count, want.data, want.valid, want.last, want.err,
                     got.data, got.valid, got.last, got.err);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
